FILE: src/rsj_pkg.sv
// Shared types and codes for the range scan jump segmenter.
package rsj_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_GAP_THRESHOLD_SQ   = 3'd0;
   localparam logic [2:0] CSR_MIN_POINTS         = 3'd1;
   localparam logic [2:0] CSR_MAX_CENTER_DIST_SQ = 3'd2;
   localparam logic [2:0] CSR_COS_STEP           = 3'd3;
   localparam logic [2:0] CSR_SIN_STEP           = 3'd4;
   localparam logic [2:0] CSR_COS_START          = 3'd5;
   localparam logic [2:0] CSR_SIN_START          = 3'd6;

   // Shared multiplier operations, AB to CS issued in this order per sample
   localparam logic [3:0] OP_AB  = 4'd0;
   localparam logic [3:0] OP_AA  = 4'd1;
   localparam logic [3:0] OP_BB  = 4'd2;
   localparam logic [3:0] OP_ABC = 4'd3;
   localparam logic [3:0] OP_XC  = 4'd4;
   localparam logic [3:0] OP_YS  = 4'd5;
   localparam logic [3:0] OP_CC  = 4'd6;
   localparam logic [3:0] OP_SS  = 4'd7;
   localparam logic [3:0] OP_SC  = 4'd8;
   localparam logic [3:0] OP_CS  = 4'd9;
   localparam logic [3:0] OP_XX  = 4'd10;
   localparam logic [3:0] OP_YY  = 4'd11;

   localparam int SAMPLE_OPS = 10;

   typedef struct packed {
      logic       accept;
      logic       mul_en;
      logic [3:0] op;
      logic       update;
      logic       div_step;
      logic       fix;
      logic       publish;
   } rsj_cmd_type;

   typedef struct packed {
      logic cand;
      logic out_full;
   } rsj_sts_type;

endpackage

FILE: src/range_scan_jump_segmenter.sv
// Top level of the range scan jump segmenter.
// One range sample per transfer; neighbors are split where the squared
// law-of-cosines gap exceeds gap_threshold_sq, and each closed segment whose
// counted points reach min_points and whose rounded centroid lies strictly
// inside max_center_dist_sq comes out as one result transfer. A sample goes
// from acceptance to the next ready through accept, ten passes through the
// single shared multiplier, one drain and one state update; a sample that
// closes a segment with enough points adds the restoring division of the x
// and y sums, one quotient bit per cycle, then a sign fix, two multiplier
// passes for the range check and a publish that waits while the result
// register is full. A result waits in its own output register while the next
// sample is taken. Configuration writes are always ready and apply at once;
// cos_start and sin_start are picked up at the next scan start.
module range_scan_jump_segmenter
   import rsj_pkg::*;
#(
   parameter int MAX_BEAMS  = 4096,
   parameter int RANGE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] range_mm
   input  logic        req_tuser,   // [0] first_sample
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // center_x, center_y, first_beam, last_beam, point_total
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int DIV_STEPS = RANGE_BITS + $clog2(MAX_BEAMS) + 3;

   rsj_cmd_type cmd;
   rsj_sts_type sts;

   // configuration transfers never stall
   assign csr_ready = 1'b1;

   rsj_controller #(
      .DIV_STEPS(DIV_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rsj_datapath #(
      .MAX_BEAMS  (MAX_BEAMS),
      .RANGE_BITS (RANGE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .range_mm     (req_tdata),
      .first_sample (req_tuser),
      .last_sample  (req_tlast),
      .csr_valid    (csr_valid),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

FILE: src/rsj_datapath.sv
// Datapath: config registers, shared multiplier, scan state, divider, result register.
module rsj_datapath
   import rsj_pkg::*;
#(
   parameter int MAX_BEAMS  = 4096,
   parameter int RANGE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  rsj_cmd_type       cmd,
   output rsj_sts_type       sts,
   input  logic [15:0]       range_mm,
   input  logic              first_sample,
   input  logic              last_sample,
   input  logic              csr_valid,
   input  logic [2:0]        csr_addr,
   input  logic [31:0]       csr_wdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata
);

   localparam int RW = RANGE_BITS;
   localparam int IW = $clog2(MAX_BEAMS);
   localparam int CW = IW + 1;
   localparam int SW = RW + IW + 2;
   localparam int DW = SW + 1;
   localparam int XW = RW + 1;
   localparam int AW = 2 * RW + 1;
   localparam int BW = ((RW > 16) ? RW : 16) + 1;
   localparam int PW = AW + BW;
   localparam int GW = (2 * RW + 18 > 49) ? 2 * RW + 18 : 49;

   // configuration
   logic [31:0]        gap_thr_ff, max_dist_ff;
   logic [12:0]        min_points_ff;
   logic signed [15:0] cos_step_ff, sin_step_ff, cos_start_ff, sin_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_thr_ff    <= 32'd10000;
         min_points_ff <= 13'd3;
         max_dist_ff   <= 32'd25000000;
         cos_step_ff   <= 16'sd32767;
         sin_step_ff   <= 16'sd206;
         cos_start_ff  <= 16'sd32767;
         sin_start_ff  <= 16'sd0;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_GAP_THRESHOLD_SQ:   gap_thr_ff    <= csr_wdata;
            CSR_MIN_POINTS:         min_points_ff <= csr_wdata[12:0];
            CSR_MAX_CENTER_DIST_SQ: max_dist_ff   <= csr_wdata;
            CSR_COS_STEP:           cos_step_ff   <= csr_wdata[15:0];
            CSR_SIN_STEP:           sin_step_ff   <= csr_wdata[15:0];
            CSR_COS_START:          cos_start_ff  <= csr_wdata[15:0];
            CSR_SIN_START:          sin_start_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // captured sample and scan state
   logic [RW-1:0]        r_ff, prev_ff;
   logic                 ls_ff, start_ff;
   logic signed [15:0]   beam_cos_ff, beam_sin_ff;
   logic [CW-1:0]        points_ff;
   logic [IW-1:0]        idx_ff, first_ff;
   logic signed [SW-1:0] sum_x_ff, sum_y_ff;

   // multiplier and its products
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] prod_ff, rot_ff, sq_ff;
   logic [3:0]           op_ff;
   logic                 use_ff;
   logic [2*RW:0]        gacc_ff;
   logic [2*RW-1:0]      ab_ff;
   logic                 jump_ff, in_range_ff;
   logic signed [XW-1:0] px_ff, py_ff, cx_ff, cy_ff;
   logic signed [15:0]   nc_ff, ns_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_AA: begin
            mul_a = AW'($signed({1'b0, prev_ff}));
            mul_b = BW'($signed({1'b0, prev_ff}));
         end
         OP_BB: begin
            mul_a = AW'($signed({1'b0, r_ff}));
            mul_b = BW'($signed({1'b0, r_ff}));
         end
         OP_AB: begin
            mul_a = AW'($signed({1'b0, prev_ff}));
            mul_b = BW'($signed({1'b0, r_ff}));
         end
         OP_ABC: begin
            mul_a = AW'($signed({1'b0, ab_ff}));
            mul_b = BW'(cos_step_ff);
         end
         OP_XC: begin
            mul_a = AW'($signed({1'b0, r_ff}));
            mul_b = BW'(beam_cos_ff);
         end
         OP_YS: begin
            mul_a = AW'($signed({1'b0, r_ff}));
            mul_b = BW'(beam_sin_ff);
         end
         OP_CC: begin
            mul_a = AW'(beam_cos_ff);
            mul_b = BW'(cos_step_ff);
         end
         OP_SS: begin
            mul_a = AW'(beam_sin_ff);
            mul_b = BW'(sin_step_ff);
         end
         OP_SC: begin
            mul_a = AW'(beam_sin_ff);
            mul_b = BW'(cos_step_ff);
         end
         OP_CS: begin
            mul_a = AW'(beam_cos_ff);
            mul_b = BW'(sin_step_ff);
         end
         OP_XX: begin
            mul_a = AW'(cx_ff);
            mul_b = BW'(cx_ff);
         end
         OP_YY: begin
            mul_a = AW'(cy_ff);
            mul_b = BW'(cy_ff);
         end
         default: ;
      endcase
   end

   // consumers of the registered product
   logic signed [GW-1:0] gap_lhs, gap_rhs;
   logic signed [PW:0]   rot_rnd, prod_rnd;
   logic signed [PW:0]   sq_sum;

   always_comb begin
      gap_lhs = GW'($signed({1'b0, gacc_ff, 15'b0})) - (GW'(prod_ff) <<< 1);
      gap_rhs = GW'($signed({1'b0, gap_thr_ff, 15'b0}));
      prod_rnd = (PW + 1)'(prod_ff) + (PW + 1)'(16384);
      if (op_ff == OP_SS) begin
         rot_rnd = ((PW + 1)'(rot_ff) - (PW + 1)'(prod_ff) + (PW + 1)'(16384)) >>> 15;
      end else begin
         rot_rnd = ((PW + 1)'(rot_ff) + (PW + 1)'(prod_ff) + (PW + 1)'(16384)) >>> 15;
      end
      sq_sum = (PW + 1)'(sq_ff) + (PW + 1)'(prod_ff);
   end

   function automatic logic signed [15:0] sat16(input logic signed [PW:0] v);
      if (v > (PW + 1)'(32767)) begin
         return 16'sh7fff;
      end else if (v < -(PW + 1)'(32768)) begin
         return -16'sh8000;
      end
      return 16'(v);
   endfunction

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a * mul_b);
      op_ff   <= cmd.op;
      if (reset) begin
         use_ff <= 1'b0;
      end else begin
         use_ff <= cmd.mul_en;
      end
      if (use_ff) begin
         case (op_ff)
            OP_AA:  gacc_ff <= (2 * RW + 1)'(prod_ff);
            OP_BB:  gacc_ff <= gacc_ff + (2 * RW + 1)'(prod_ff);
            OP_AB:  ab_ff   <= (2 * RW)'(prod_ff);
            OP_ABC: jump_ff <= gap_lhs > gap_rhs;
            OP_XC:  px_ff   <= XW'(prod_rnd >>> 15);
            OP_YS:  py_ff   <= XW'(prod_rnd >>> 15);
            OP_CC:  rot_ff  <= prod_ff;
            OP_SS:  nc_ff   <= sat16(rot_rnd);
            OP_SC:  rot_ff  <= prod_ff;
            OP_CS:  ns_ff   <= sat16(rot_rnd);
            OP_XX:  sq_ff   <= prod_ff;
            OP_YY:  in_range_ff <= sq_sum < (PW + 1)'($signed({1'b0, max_dist_ff}));
            default: ;
         endcase
      end
   end

   // segment bookkeeping
   logic [IW:0]          idx1;
   logic                 last_beam;
   logic [CW-1:0]        cand_n, cand_cnt;
   logic [IW-1:0]        cand_last;
   logic signed [SW-1:0] cand_sx, cand_sy, mag_x, mag_y;
   logic                 cand_ok;

   always_comb begin
      idx1      = (IW + 1)'(idx_ff) + (IW + 1)'(1);
      last_beam = ls_ff || (idx1 >= (IW + 1)'(MAX_BEAMS - 1));
      cand_ok   = 1'b0;
      cand_n    = points_ff;
      cand_cnt  = points_ff;
      cand_last = idx_ff;
      cand_sx   = sum_x_ff;
      cand_sy   = sum_y_ff;
      if (!start_ff) begin
         if (last_beam) begin
            cand_ok   = 1'b1;
            cand_n    = points_ff + CW'(1);
            cand_last = IW'(idx1);
            cand_sx   = sum_x_ff + SW'(px_ff);
            cand_sy   = sum_y_ff + SW'(py_ff);
         end else if (jump_ff) begin
            cand_ok = 1'b1;
         end
      end
      mag_x = (cand_sx < 0) ? -cand_sx : cand_sx;
      mag_y = (cand_sy < 0) ? -cand_sy : cand_sy;
   end

   logic rsp_valid_ff;

   assign sts = '{cand: cand_ok && (cand_n != '0) &&
                        (32'(cand_cnt) >= 32'(min_points_ff)),
                  out_full: rsp_valid_ff && !rsp_tready};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         r_ff     <= RW'(range_mm);
         ls_ff    <= last_sample;
         start_ff <= first_sample || (points_ff == '0);
         if (first_sample || (points_ff == '0)) begin
            beam_cos_ff <= cos_start_ff;
            beam_sin_ff <= sin_start_ff;
         end
      end
      if (cmd.update) begin
         beam_cos_ff <= nc_ff;
         beam_sin_ff <= ns_ff;
         prev_ff     <= r_ff;
         if (start_ff) begin
            idx_ff   <= '0;
            first_ff <= '0;
            sum_x_ff <= SW'(px_ff);
            sum_y_ff <= SW'(py_ff);
         end else begin
            idx_ff <= IW'(idx1);
            if (last_beam) begin
               sum_x_ff <= cand_sx;
               sum_y_ff <= cand_sy;
            end else if (jump_ff) begin
               sum_x_ff <= SW'(px_ff);
               sum_y_ff <= SW'(py_ff);
               first_ff <= IW'(idx1);
            end else begin
               sum_x_ff <= sum_x_ff + SW'(px_ff);
               sum_y_ff <= sum_y_ff + SW'(py_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
      end else if (cmd.update) begin
         if (start_ff) begin
            points_ff <= ls_ff ? '0 : CW'(1);
         end else if (last_beam) begin
            points_ff <= '0;
         end else if (jump_ff) begin
            points_ff <= CW'(1);
         end else begin
            points_ff <= points_ff + CW'(1);
         end
      end
   end

   // restoring dividers for x and y, one quotient bit per step
   logic [CW-1:0] dvs_ff, rem_x_ff, rem_y_ff;
   logic [DW-1:0] quo_x_ff, quo_y_ff;
   logic          neg_x_ff, neg_y_ff;
   logic [IW-1:0] res_first_ff, res_last_ff;
   logic [CW-1:0] res_n_ff;
   logic [CW:0]   sh_x, sh_y;

   assign sh_x = {rem_x_ff, quo_x_ff[DW-1]};
   assign sh_y = {rem_y_ff, quo_y_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         dvs_ff       <= cand_n;
         rem_x_ff     <= '0;
         rem_y_ff     <= '0;
         quo_x_ff     <= DW'(mag_x) + DW'(cand_n >> 1);
         quo_y_ff     <= DW'(mag_y) + DW'(cand_n >> 1);
         neg_x_ff     <= cand_sx < 0;
         neg_y_ff     <= cand_sy < 0;
         res_first_ff <= first_ff;
         res_last_ff  <= cand_last;
         res_n_ff     <= cand_n;
      end else if (cmd.div_step) begin
         if (sh_x >= {1'b0, dvs_ff}) begin
            rem_x_ff <= CW'(sh_x - {1'b0, dvs_ff});
            quo_x_ff <= {quo_x_ff[DW-2:0], 1'b1};
         end else begin
            rem_x_ff <= CW'(sh_x);
            quo_x_ff <= {quo_x_ff[DW-2:0], 1'b0};
         end
         if (sh_y >= {1'b0, dvs_ff}) begin
            rem_y_ff <= CW'(sh_y - {1'b0, dvs_ff});
            quo_y_ff <= {quo_y_ff[DW-2:0], 1'b1};
         end else begin
            rem_y_ff <= CW'(sh_y);
            quo_y_ff <= {quo_y_ff[DW-2:0], 1'b0};
         end
      end
      if (cmd.fix) begin
         cx_ff <= neg_x_ff ? XW'(-$signed({1'b0, quo_x_ff})) : XW'($signed({1'b0, quo_x_ff}));
         cy_ff <= neg_y_ff ? XW'(-$signed({1'b0, quo_y_ff})) : XW'($signed({1'b0, quo_y_ff}));
      end
   end

   // result register
   logic [71:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish && in_range_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.publish && in_range_ff) begin
         rsp_data_ff <= {1'b0, 13'(res_n_ff), 12'(res_last_ff), 12'(res_first_ff),
                         17'(cy_ff), 17'(cx_ff)};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

endmodule

FILE: src/rsj_controller.sv
// Controller: sequences multiplier ops and update per sample, then division, check and publish per qualifying segment.
module rsj_controller
   import rsj_pkg::*;
#(
   parameter int DIV_STEPS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output rsj_cmd_type cmd,
   input  rsj_sts_type sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIX  = 3'd4;
   localparam logic [2:0] ST_SQ   = 3'd5;
   localparam logic [2:0] ST_PUB  = 3'd6;

   localparam int NW = $clog2(DIV_STEPS + 1);

   logic [2:0]    state_ff, state_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            if (32'(cnt_ff) < SAMPLE_OPS) begin
               cmd.mul_en = 1'b1;
               cmd.op     = 4'(cnt_ff);
               cnt_in     = cnt_ff + NW'(1);
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = sts.cand ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + NW'(1);
            if (cnt_ff == NW'(DIV_STEPS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            cnt_in   = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(0)) begin
               cmd.mul_en = 1'b1;
               cmd.op     = OP_XX;
            end else if (cnt_ff == NW'(1)) begin
               cmd.mul_en = 1'b1;
               cmd.op     = OP_YY;
            end else begin
               state_in = ST_PUB;
            end
         end
         ST_PUB: begin
            if (!sts.out_full) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

FILE: test/rsj_checker.sv
// Scoreboard for the range scan jump segmenter: predicts segment results and compares them.
`timescale 1ns / 1ps
module rsj_checker
   import rsj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   localparam int BEAM_LIMIT = 4096;

   logic [31:0] gap_sq, dist_sq;
   logic [12:0] min_pts;
   longint c_step, s_step, c_start, s_start;

   longint cur_cos, cur_sin, sx, sy;
   longint prev_r;
   int unsigned seg_pts, seg_first, beam_idx;

   logic [71:0] segment_queue[$];

   assign pending_count = segment_queue.size();

   function automatic longint q15_round(longint v);
      longint t;
      t = v + 16384;
      if (t >= 0) return t / 32768;
      return -((-t + 32767) / 32768);
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint round_div(longint s, longint n);
      longint m, q;
      m = s < 0 ? -s : s;
      q = (m + n / 2) / n;
      return s < 0 ? -q : q;
   endfunction

   // Point of the current beam, then rotate the beam direction.
   task automatic project_point(input longint r, output longint x, output longint y);
      longint nc, ns;
      x = q15_round(r * cur_cos);
      y = q15_round(r * cur_sin);
      nc = clamp16(q15_round(cur_cos * c_step - cur_sin * s_step));
      ns = clamp16(q15_round(cur_sin * c_step + cur_cos * s_step));
      cur_cos = nc;
      cur_sin = ns;
   endtask

   task automatic close_segment(input longint n, input longint counted,
                                input int unsigned first, input int unsigned last);
      longint cx, cy;
      logic [63:0] d;
      logic [16:0] px, py;
      logic [11:0] fb, lb;
      logic [12:0] nt;
      if (n == 0 || counted < min_pts) return;
      cx = round_div(sx, n);
      cy = round_div(sy, n);
      d = 64'(cx * cx) + 64'(cy * cy);
      if (d >= {32'd0, dist_sq}) return;
      px = cx[16:0];
      py = cy[16:0];
      fb = first[11:0];
      lb = last[11:0];
      nt = n[12:0];
      segment_queue = {segment_queue, 72'({nt, lb, fb, py, px})};
   endtask

   task automatic take_sample(input logic [15:0] r, input logic fs, input logic ls);
      longint x, y, a, b, g;
      int unsigned idx;
      bit fin, jump;
      if (fs || seg_pts == 0) begin
         beam_idx = 0;
         cur_cos = c_start;
         cur_sin = s_start;
         project_point(longint'(r), x, y);
         sx = x;
         sy = y;
         seg_first = 0;
         seg_pts = ls ? 0 : 1;
         prev_r = r;
         return;
      end
      idx = beam_idx + 1;
      fin = ls || idx >= BEAM_LIMIT - 1;
      a = prev_r;
      b = longint'(r);
      g = (a * a + b * b) * 32768 - 2 * a * b * c_step;
      jump = g > longint'(gap_sq) * 32768;
      project_point(b, x, y);
      if (fin) begin
         sx += x;
         sy += y;
         close_segment(seg_pts + 1, seg_pts, seg_first, idx);
         seg_pts = 0;
      end else if (jump) begin
         close_segment(seg_pts, seg_pts, seg_first, idx - 1);
         sx = x;
         sy = y;
         seg_first = idx;
         seg_pts = 1;
      end else begin
         sx += x;
         sy += y;
         seg_pts++;
      end
      prev_r = b;
      beam_idx = idx;
   endtask

   always @(posedge clock) begin
      logic [71:0] want;
      if (reset) begin
         gap_sq = 10000;
         min_pts = 3;
         dist_sq = 25000000;
         c_step = 32767;
         s_step = 206;
         c_start = 32767;
         s_start = 0;
         cur_cos = c_start;
         cur_sin = s_start;
         prev_r = 0;
         sx = 0;
         sy = 0;
         seg_pts = 0;
         seg_first = 0;
         beam_idx = 0;
         segment_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_GAP_THRESHOLD_SQ:   gap_sq = csr_wdata;
               CSR_MIN_POINTS:         min_pts = csr_wdata[12:0];
               CSR_MAX_CENTER_DIST_SQ: dist_sq = csr_wdata;
               CSR_COS_STEP:           c_step = longint'(signed'(csr_wdata[15:0]));
               CSR_SIN_STEP:           s_step = longint'(signed'(csr_wdata[15:0]));
               CSR_COS_START:          c_start = longint'(signed'(csr_wdata[15:0]));
               CSR_SIN_START:          s_start = longint'(signed'(csr_wdata[15:0]));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (segment_queue.size() == 0) begin
               $display("%0t: unexpected segment result %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = segment_queue.pop_front();
               if (want[16:0] !== rsp_tdata[16:0]) begin
                  $display("%0t: center_x expected %0d got %0d", $time,
                           signed'(want[16:0]), signed'(rsp_tdata[16:0]));
                  fail_count++;
               end
               if (want[33:17] !== rsp_tdata[33:17]) begin
                  $display("%0t: center_y expected %0d got %0d", $time,
                           signed'(want[33:17]), signed'(rsp_tdata[33:17]));
                  fail_count++;
               end
               if (want[45:34] !== rsp_tdata[45:34]) begin
                  $display("%0t: first_beam expected %0d got %0d", $time,
                           want[45:34], rsp_tdata[45:34]);
                  fail_count++;
               end
               if (want[57:46] !== rsp_tdata[57:46]) begin
                  $display("%0t: last_beam expected %0d got %0d", $time,
                           want[57:46], rsp_tdata[57:46]);
                  fail_count++;
               end
               if (want[70:58] !== rsp_tdata[70:58]) begin
                  $display("%0t: point_total expected %0d got %0d", $time,
                           want[70:58], rsp_tdata[70:58]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            take_sample(req_tdata, req_tuser, req_tlast);
      end
   end
endmodule

FILE: test/tb_range_scan_jump_segmenter.sv
// Testbench top for the range scan jump segmenter: stimulus, clocking and verdict.
`timescale 1ns / 1ps
module tb_range_scan_jump_segmenter;
   import rsj_pkg::*;

   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic [2:0] CSR_UNMAPPED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   int     fail_count, pending_count;
   longint cycle_count = 0;
   int     burst_left = 0;
   int     stall_mode = 0;

   always #2 clock = ~clock;

   range_scan_jump_segmenter DUT (.*);

   rsj_checker checker_inst (.*);

   // Abort on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver stalls: cycle through modes of no stall, light stall and heavy stall.
   always @(posedge clock) begin
      if (cycle_count % 3000 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Transfer one sample; idle gaps between random bursts.
   task automatic send_sample(input logic [15:0] r, input logic fs, input logic ls);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         repeat ($urandom_range(0, 40)) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= r;
      req_tuser <= fs;
      req_tlast <= ls;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One scan of smooth ranges with occasional jumps and noise.
   task automatic send_scan(input int beams, input int base, input int jump_odds);
      int r;
      r = base;
      for (int i = 0; i < beams; i++) begin
         if ($urandom_range(0, 99) < jump_odds)
            r = $urandom_range(0, 65535);
         else
            r = r + $urandom_range(0, 40) - 20;
         if (r < 0) r = 0;
         if (r > 65535) r = 65535;
         send_sample(r[15:0], i == 0 ? ($urandom_range(0, 7) != 0) : 1'b0,
                     i == beams - 1);
      end
   endtask

   task automatic random_config();
      write_csr(CSR_GAP_THRESHOLD_SQ, $urandom_range(0, 3) == 0 ? $urandom() :
                $urandom_range(0, 200000));
      write_csr(CSR_MIN_POINTS, $urandom_range(0, 6));
      write_csr(CSR_MAX_CENTER_DIST_SQ, $urandom_range(0, 3) == 0 ? $urandom() :
                32'hFFFF_FFFF);
      write_csr(CSR_COS_STEP, $urandom_range(0, 1) ? 32'd32767 : $urandom());
      write_csr(CSR_SIN_STEP, $urandom());
      write_csr(CSR_COS_START, $urandom());
      write_csr(CSR_SIN_START, $urandom());
   endtask

   initial begin
      int sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-beam scan, extremes of range, a jump, a sample with no
      // scan in progress and flags cleared.
      send_sample(16'd1000, 1'b1, 1'b1);
      send_sample(16'd1000, 1'b0, 1'b0);
      send_sample(16'd1001, 1'b0, 1'b0);
      send_sample(16'd1002, 1'b0, 1'b0);
      send_sample(16'd1003, 1'b0, 1'b0);
      send_sample(16'd65535, 1'b0, 1'b0);
      send_sample(16'd65535, 1'b0, 1'b0);
      send_sample(16'd0, 1'b0, 1'b0);
      send_sample(16'd0, 1'b0, 1'b0);
      send_sample(16'd0, 1'b0, 1'b1);
      send_sample(16'd500, 1'b1, 1'b0);
      send_sample(16'd501, 1'b1, 1'b0);
      send_sample(16'd502, 1'b0, 1'b0);
      send_sample(16'd503, 1'b0, 1'b1);
      // Hold off until every expected segment is out.
      drain_results();

      // Extremes of every register.
      write_csr(CSR_GAP_THRESHOLD_SQ, 32'hFFFF_FFFF);
      write_csr(CSR_MIN_POINTS, 32'd0);
      write_csr(CSR_MAX_CENTER_DIST_SQ, 32'hFFFF_FFFF);
      write_csr(CSR_COS_STEP, 32'h0000_8000);
      write_csr(CSR_SIN_STEP, 32'h0000_7FFF);
      write_csr(CSR_COS_START, 32'h0000_8000);
      write_csr(CSR_SIN_START, 32'h0000_7FFF);
      write_csr(CSR_UNMAPPED, 32'hDEAD_BEEF);
      send_sample(16'd65535, 1'b1, 1'b0);
      send_sample(16'd65535, 1'b0, 1'b0);
      send_sample(16'd0, 1'b0, 1'b0);
      send_sample(16'd65535, 1'b0, 1'b1);
      drain_results();

      write_csr(CSR_GAP_THRESHOLD_SQ, 32'd0);
      write_csr(CSR_MIN_POINTS, 32'd4096);
      write_csr(CSR_MAX_CENTER_DIST_SQ, 32'd0);
      send_scan(5, 3000, 0);
      drain_results();

      // One long smooth scan.
      write_csr(CSR_GAP_THRESHOLD_SQ, 32'd10000);
      write_csr(CSR_MIN_POINTS, 32'd1);
      write_csr(CSR_MAX_CENTER_DIST_SQ, 32'hFFFF_FFFF);
      write_csr(CSR_COS_STEP, 32'd32767);
      write_csr(CSR_SIN_STEP, 32'd206);
      write_csr(CSR_COS_START, 32'd32767);
      write_csr(CSR_SIN_START, 32'd0);
      for (int i = 0; i < 200; i++)
         send_sample(16'd2000 + 16'(i % 3), i == 0, i == 199);
      drain_results();

      // Random scans in phases with fresh settings.
      sent = 0;
      while (sent < 950) begin
         random_config();
         for (int s = 0; s < 8; s++) begin
            int beams;
            beams = $urandom_range(2, 30);
            send_scan(beams, $urandom_range(0, 65535), $urandom_range(0, 25));
            sent += beams;
         end
         drain_results();
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
